// ===== hw/rtl/uwp_pkg.sv =====
// Shared types and constants of the window pager.
// No dependencies; used by uwp_table, uwp_ctrl and unibus_window_pager_core.
`default_nettype none

package uwp_pkg;

  // Page table geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

  // Widths of the stream payloads
  localparam int ADDR_W  = 20;
  localparam int WORD_W  = 36;
  localparam int HALF_W  = 16;
  localparam int BUS_W   = 3;
  localparam int BADDR_W = 19;
  localparam int OFS_W   = 10;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 80;

  // Address map
  localparam logic [ADDR_W-1:0] CTRL_BASE  = 20'o3776000;
  localparam logic [OFS_W-1:0]  CTRL_LIMIT = 10'o400;

  // Page table entry layout
  localparam int E_VALID_BIT = 35;
  localparam int E_BUS_LSB   = 26;
  localparam int E_BASE_LSB  = 10;
  localparam int E_LIMIT_LSB = 0;

  // Host write data inhibit bits
  localparam int WR_INH_FIRST  = 3;
  localparam int WR_INH_SECOND = 2;

  // Input item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  // Bus read status
  localparam logic [1:0] BSTAT_ACK = 2'd0;

  // Result kinds
  localparam logic [1:0] RK_DONE   = 2'd0;
  localparam logic [1:0] RK_FAULT  = 2'd1;
  localparam logic [1:0] RK_BUS_RD = 2'd2;
  localparam logic [1:0] RK_BUS_WR = 2'd3;

  // Page table access request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [TBL_AW-1:0] rd_addr;
    logic              wr_en;
    logic [TBL_AW-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uwp_table.sv =====
// Page table: one synchronous RAM with registered read, plus per-entry valid bits.
// Depends on uwp_pkg. An entry never written reads as zero (invalid page).
`default_nettype none

module uwp_table (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire uwp_pkg::tbl_req_t         req,
  output logic [uwp_pkg::WORD_W-1:0]     rd_data
);

  logic [uwp_pkg::WORD_W-1:0]        mem [uwp_pkg::TABLE_ENTRIES];
  logic [uwp_pkg::TABLE_ENTRIES-1:0] vld;
  logic [uwp_pkg::WORD_W-1:0]        q;
  logic                              q_vld;

  // RAM write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q <= mem[req.rd_addr];
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        q_vld <= vld[req.rd_addr];
      end
    end
  end

  assign rd_data = q_vld ? q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/uwp_ctrl.sv =====
// Access sequencer: takes host and bus return transactions, looks up the page
// table, builds the result list and emits it. Depends on uwp_pkg.
`default_nettype none

module uwp_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [uwp_pkg::S_DATA_W-1:0]  s_tdata,
  input  wire logic [1:0]                    s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [uwp_pkg::M_DATA_W-1:0]       m_tdata,
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast,
  // page table
  output uwp_pkg::tbl_req_t                  tbl_req,
  input  wire logic [uwp_pkg::WORD_W-1:0]    tbl_rd_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [uwp_pkg::WORD_W-1:0]   rdata;
    logic [uwp_pkg::BUS_W-1:0]    bus;
    logic [uwp_pkg::BADDR_W-1:0]  baddr;
    logic [uwp_pkg::HALF_W-1:0]   bdata;
    logic                         last;
  } res_t;

  function automatic res_t mk_res(
    input logic [1:0]                  kind,
    input logic [uwp_pkg::WORD_W-1:0]  rdata,
    input logic [uwp_pkg::BUS_W-1:0]   bus,
    input logic [uwp_pkg::BADDR_W-1:0] baddr,
    input logic [uwp_pkg::HALF_W-1:0]  bdata,
    input logic                        last
  );
    res_t r;
    r.kind  = kind;
    r.rdata = rdata;
    r.bus   = bus;
    r.baddr = baddr;
    r.bdata = bdata;
    r.last  = last;
    return r;
  endfunction

  state_t state;
  state_t state_next;

  // Latched input transaction
  logic [1:0]                   it_kind;
  logic [uwp_pkg::ADDR_W-1:0]   it_addr;
  logic [uwp_pkg::WORD_W-1:0]   it_wdata;
  logic [uwp_pkg::HALF_W-1:0]   it_bword;
  logic [1:0]                   it_bstat;

  // Read collection state
  logic                         read_pending;
  logic                         read_pending_next;
  logic                         halves;
  logic                         halves_next;
  logic [uwp_pkg::HALF_W-1:0]   first_half;
  logic [uwp_pkg::HALF_W-1:0]   first_half_next;

  // Result list
  res_t       res [3];
  res_t       res_next [3];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] idx;

  // Lookup decode
  logic [uwp_pkg::ADDR_W-1:0]   s_addr;
  logic [uwp_pkg::OFS_W-1:0]    ofs;
  logic [7:0]                   page;
  logic                         ctrl_hit;
  logic                         ctrl_ok;
  logic                         page_ok;
  logic                         map_ok;
  logic [uwp_pkg::BUS_W-1:0]    e_bus;
  logic [15:0]                  e_base;
  logic [uwp_pkg::OFS_W-1:0]    e_limit;
  logic [16:0]                  sum;
  logic [uwp_pkg::HALF_W-1:0]   bword_eff;
  logic                         wr_first;
  logic                         wr_second;
  res_t                         r_done;
  res_t                         r_fault;
  res_t                         r_wr0;
  res_t                         r_wr1;

  // Input handshake, table read issue and control page table write
  assign s_tready = (state == ST_IDLE);
  assign s_addr   = s_tdata[19:0];

  always_comb begin
    tbl_req.rd_en   = s_tvalid && s_tready;
    tbl_req.rd_addr = (s_addr >= uwp_pkg::CTRL_BASE) ? s_addr[uwp_pkg::TBL_AW-1:0]
                                                     : s_addr[10 +: uwp_pkg::TBL_AW];
    tbl_req.wr_en   = (state == ST_LOOK) && (it_kind == uwp_pkg::KIND_WRITE) &&
                      ctrl_hit && ctrl_ok;
    tbl_req.wr_addr = ofs[uwp_pkg::TBL_AW-1:0];
    tbl_req.wr_data = it_wdata;
  end

  // Address and entry decode on the latched transaction
  assign ofs      = it_addr[9:0];
  assign page     = it_addr[17:10];
  assign ctrl_hit = (it_addr >= uwp_pkg::CTRL_BASE);
  assign ctrl_ok  = (ofs < uwp_pkg::CTRL_LIMIT) &&
                    ({1'b0, ofs} < 11'(uwp_pkg::TABLE_ENTRIES));
  assign page_ok  = ({1'b0, page} < 9'(uwp_pkg::TABLE_ENTRIES));
  assign e_bus    = tbl_rd_data[uwp_pkg::E_BUS_LSB +: uwp_pkg::BUS_W];
  assign e_base   = tbl_rd_data[uwp_pkg::E_BASE_LSB +: 16];
  assign e_limit  = tbl_rd_data[uwp_pkg::E_LIMIT_LSB +: uwp_pkg::OFS_W];
  assign map_ok   = page_ok && tbl_rd_data[uwp_pkg::E_VALID_BIT] && (ofs <= e_limit);
  assign sum      = {1'b0, e_base} + {7'b0, ofs};
  assign bword_eff = (it_bstat == uwp_pkg::BSTAT_ACK) ? it_bword : '0;
  assign wr_first  = !it_wdata[uwp_pkg::WR_INH_FIRST];
  assign wr_second = !it_wdata[uwp_pkg::WR_INH_SECOND];

  assign r_done  = mk_res(uwp_pkg::RK_DONE, '0, '0, '0, '0, 1'b1);
  assign r_fault = mk_res(uwp_pkg::RK_FAULT, '0, '0, '0, '0, 1'b1);
  assign r_wr0   = mk_res(uwp_pkg::RK_BUS_WR, '0, e_bus, {sum, 2'b00},
                          it_wdata[35:20], 1'b0);
  assign r_wr1   = mk_res(uwp_pkg::RK_BUS_WR, '0, e_bus, {sum, 2'b10},
                          it_wdata[19:4], 1'b0);

  // Result list and collection state for the transaction in lookup
  always_comb begin
    read_pending_next = read_pending;
    halves_next       = halves;
    first_half_next   = first_half;
    cnt_next          = 2'd0;
    res_next[0]       = r_done;
    res_next[1]       = r_done;
    res_next[2]       = r_done;
    case (it_kind)
      uwp_pkg::KIND_DATA: begin
        if (read_pending) begin
          if (!halves) begin
            first_half_next = bword_eff;
            halves_next     = 1'b1;
          end else begin
            read_pending_next = 1'b0;
            halves_next       = 1'b0;
            res_next[0] = mk_res(uwp_pkg::RK_DONE, {first_half, bword_eff, 4'b0000},
                                 '0, '0, '0, 1'b1);
            cnt_next    = 2'd1;
          end
        end
      end
      uwp_pkg::KIND_READ, uwp_pkg::KIND_WRITE: begin
        if (it_kind == uwp_pkg::KIND_READ) begin
          read_pending_next = 1'b0;
          halves_next       = 1'b0;
        end
        cnt_next = 2'd1;
        if (ctrl_hit) begin
          if (!ctrl_ok) begin
            res_next[0] = r_fault;
          end else if (it_kind == uwp_pkg::KIND_READ) begin
            res_next[0] = mk_res(uwp_pkg::RK_DONE, tbl_rd_data, '0, '0, '0, 1'b1);
          end
        end else if (!map_ok) begin
          res_next[0] = r_fault;
        end else if (it_kind == uwp_pkg::KIND_READ) begin
          res_next[0] = mk_res(uwp_pkg::RK_BUS_RD, '0, e_bus, {sum, 2'b00}, '0, 1'b0);
          res_next[1] = mk_res(uwp_pkg::RK_BUS_RD, '0, e_bus, {sum, 2'b10}, '0, 1'b1);
          cnt_next    = 2'd2;
          read_pending_next = 1'b1;
        end else begin
          // bus writes in order, each one dropped by its inhibit bit
          res_next[0] = wr_first ? r_wr0 : (wr_second ? r_wr1 : r_done);
          res_next[1] = (wr_first && wr_second) ? r_wr1 : r_done;
          cnt_next    = 2'd1 + {1'b0, wr_first} + {1'b0, wr_second};
        end
      end
      default: begin
        cnt_next = 2'd0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_LOOK;
      ST_LOOK: state_next = (cnt_next == 2'd0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (m_tready && (idx == cnt - 2'd1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      read_pending <= 1'b0;
      halves       <= 1'b0;
      first_half   <= '0;
      cnt          <= 2'd0;
      idx          <= 2'd0;
    end else begin
      state <= state_next;
      if (state == ST_LOOK) begin
        read_pending <= read_pending_next;
        halves       <= halves_next;
        first_half   <= first_half_next;
        cnt          <= cnt_next;
        idx          <= 2'd0;
      end else if ((state == ST_EMIT) && m_tready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      it_kind  <= s_tuser;
      it_addr  <= s_tdata[19:0];
      it_wdata <= s_tdata[55:20];
      it_bword <= s_tdata[71:56];
      it_bstat <= s_tdata[73:72];
    end
    if (state == ST_LOOK) begin
      res[0] <= res_next[0];
      res[1] <= res_next[1];
      res[2] <= res_next[2];
    end
  end

  // Result stream
  assign m_tvalid = (state == ST_EMIT);
  assign m_tuser  = res[idx].kind;
  assign m_tlast  = res[idx].last;
  assign m_tdata  = {6'b0, res[idx].bdata, res[idx].baddr, res[idx].bus, res[idx].rdata};

  // One transaction at a time: never taking input while a result is shown
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while results outstanding");

  a_accept_looks_up: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_LOOK))
    else $error("accepted transaction not looked up");

  a_table_write_ctx: assert property (@(posedge clk) disable iff (rst)
    tbl_req.wr_en |-> (ctrl_hit && (it_kind == uwp_pkg::KIND_WRITE)))
    else $error("table write outside a control page write");

  a_halves_need_pending: assert property (@(posedge clk) disable iff (rst)
    halves |-> read_pending)
    else $error("halfword held with no read pending");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not reopened after final result");

endmodule

`default_nettype wire

// ===== hw/rtl/unibus_window_pager_core.sv =====
// Window pager top level: host/bus return stream in, bus cycle and completion stream out.
// Depends on uwp_pkg, uwp_table and uwp_ctrl.
//
//  Channel  Dir  tdata (low bit up)                              tuser        tlast
//  s_*      in   address, write_data, bus_word, bus_status      kind         -
//  m_*      out  read_data, bus_number, bus_address, bus_data   result_kind  last
//
// Each transaction is latched with its page table read, then looked up, then its results
// are emitted in order as m_tready takes them; the registered table RAM read sets the lookup cost.
// A transaction that gives no result goes from lookup back to idle and frees the input.
// Reset clears the table valid bits at once; every page reads invalid.
// A stalled result holds until taken; no input is taken meanwhile.
`default_nettype none

module unibus_window_pager_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // address[19:0], write_data[55:20], bus_word[71:56], bus_status[73:72]
  input  wire logic [uwp_pkg::S_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // read_data[35:0], bus_number[38:36], bus_address[57:39], bus_data[73:58]
  output logic [uwp_pkg::M_DATA_W-1:0]       m_tdata,
  // result_kind[1:0]
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast
);

  uwp_pkg::tbl_req_t           tbl_req;
  logic [uwp_pkg::WORD_W-1:0]  tbl_rd_data;

  // Page table memory
  uwp_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

  // Access sequencer
  uwp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .tbl_req     (tbl_req),
    .tbl_rd_data (tbl_rd_data)
  );

endmodule

`default_nettype wire

// ===== verif/unibus_window_pager_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for unibus_window_pager_core: directed table, then random host traffic.
// Depends on uwp_pkg and the pager RTL; results are checked against an in-bench pager model.

module unibus_window_pager_core_test;

  // Codes the package does not name
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] BSTAT_ERR   = 2'd1;
  localparam logic [1:0] BSTAT_TMO   = 2'd2;
  localparam logic [1:0] BSTAT_BAD   = 2'd3;

  // Sample page table entries: {valid, wprot, spare[4:0], bus, base, limit}
  localparam logic [35:0] ENT_TOP  = {1'b1, 1'b0, 5'h00, 3'd7, 16'hFFFF, 10'h3FF};
  localparam logic [35:0] ENT_ZERO = {1'b1, 1'b0, 5'h00, 3'd0, 16'h0000, 10'h000};
  localparam logic [35:0] ENT_WP   = {1'b1, 1'b1, 5'h1F, 3'd5, 16'h1234, 10'o17};

  typedef struct {
    logic [1:0]  kind;
    logic [19:0] addr;
    logic [35:0] wdata;
    logic [15:0] bword;
    logic [1:0]  bstat;
  } host_item_t;

  typedef struct {
    logic [1:0]  rkind;
    logic [35:0] rdata;
    logic [2:0]  bus;
    logic [18:0] baddr;
    logic [15:0] bdata;
    logic        last;
  } pager_result_t;

  typedef struct {
    host_item_t    it;
    bit            typed;
    pager_result_t want;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = uwp_pkg::KIND_READ;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  unibus_window_pager_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Pager model state
  logic [35:0] pager_table [uwp_pkg::TABLE_ENTRIES];
  logic [15:0] held_half;
  bit          half_seen;
  bit          read_open;

  pager_result_t fresh_q[$];     // results of the item just predicted
  pager_result_t expected_q[$];  // results still owed by the block
  stim_row_t     plan_q[$];

  bit quiet = 1'b0;              // no idling on either side while set
  int errors = 0;
  int items_directed = 0, items_random = 0;
  int n_checked = 0, n_done = 0, n_fault = 0, n_bus_rd = 0, n_bus_wr = 0;
  int ready_hold = 0;
  pager_result_t got_res, want_res;

  // Idle lengths: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic logic [35:0] rand_word36();
    return {4'($urandom_range(0, 15)), $urandom()};
  endfunction

  function automatic void push_result(logic [1:0] rkind, logic [35:0] rdata, logic [2:0] bus,
                                      logic [18:0] baddr, logic [15:0] bdata, logic last);
    pager_result_t r;
    r.rkind = rkind;
    r.rdata = rdata;
    r.bus   = bus;
    r.baddr = baddr;
    r.bdata = bdata;
    r.last  = last;
    fresh_q.push_back(r);
  endfunction

  function automatic void pager_reset();
    foreach (pager_table[i]) pager_table[i] = '0;
    held_half = '0;
    half_seen = 1'b0;
    read_open = 1'b0;
  endfunction

  // Pager behavior for one host item; fills fresh_q, returns 0 if the item is ignored
  function automatic bit pager_predict(host_item_t it);
    logic [9:0]  ofs;
    logic [7:0]  pg;
    logic [35:0] ent;
    logic [15:0] word;
    logic [16:0] sum;
    logic [18:0] ba;
    logic [2:0]  bn;
    ofs = it.addr[9:0];
    fresh_q.delete();
    if (it.kind == KIND_UNUSED) return 1'b0;
    // bus read data return
    if (it.kind == uwp_pkg::KIND_DATA) begin
      if (!read_open) return 1'b0;
      word = (it.bstat == uwp_pkg::BSTAT_ACK) ? it.bword : 16'h0000;
      if (!half_seen) begin
        held_half = word;
        half_seen = 1'b1;
      end else begin
        read_open = 1'b0;
        half_seen = 1'b0;
        push_result(uwp_pkg::RK_DONE, {held_half, word, 4'h0}, '0, '0, '0, 1'b1);
      end
      return 1'b1;
    end
    // a new host read drops any collection in progress
    if (it.kind == uwp_pkg::KIND_READ) begin
      read_open = 1'b0;
      half_seen = 1'b0;
    end
    // control page: table entry access
    if (it.addr >= uwp_pkg::CTRL_BASE) begin
      if (ofs >= uwp_pkg::CTRL_LIMIT || ofs >= uwp_pkg::TABLE_ENTRIES)
        push_result(uwp_pkg::RK_FAULT, '0, '0, '0, '0, 1'b1);
      else if (it.kind == uwp_pkg::KIND_READ)
        push_result(uwp_pkg::RK_DONE, pager_table[ofs[uwp_pkg::TBL_AW-1:0]],
                    '0, '0, '0, 1'b1);
      else begin
        pager_table[ofs[uwp_pkg::TBL_AW-1:0]] = it.wdata;
        push_result(uwp_pkg::RK_DONE, '0, '0, '0, '0, 1'b1);
      end
      return 1'b1;
    end
    // windowed access through the table
    pg  = it.addr[17:10];
    ent = (int'(pg) < uwp_pkg::TABLE_ENTRIES) ? pager_table[pg] : '0;
    if (!ent[uwp_pkg::E_VALID_BIT] ||
        ofs > ent[uwp_pkg::E_LIMIT_LSB +: uwp_pkg::OFS_W]) begin
      push_result(uwp_pkg::RK_FAULT, '0, '0, '0, '0, 1'b1);
      return 1'b1;
    end
    bn  = ent[uwp_pkg::E_BUS_LSB +: uwp_pkg::BUS_W];
    sum = 17'(ent[uwp_pkg::E_BASE_LSB +: uwp_pkg::HALF_W]) + 17'(ofs);
    ba  = {sum, 2'b00};
    if (it.kind == uwp_pkg::KIND_READ) begin
      push_result(uwp_pkg::RK_BUS_RD, '0, bn, ba, '0, 1'b0);
      push_result(uwp_pkg::RK_BUS_RD, '0, bn, ba + 19'd2, '0, 1'b1);
      read_open = 1'b1;
      half_seen = 1'b0;
    end else begin
      if (!it.wdata[uwp_pkg::WR_INH_FIRST])
        push_result(uwp_pkg::RK_BUS_WR, '0, bn, ba, it.wdata[35:20], 1'b0);
      if (!it.wdata[uwp_pkg::WR_INH_SECOND])
        push_result(uwp_pkg::RK_BUS_WR, '0, bn, ba + 19'd2, it.wdata[19:4], 1'b0);
      push_result(uwp_pkg::RK_DONE, '0, '0, '0, '0, 1'b1);
    end
    return 1'b1;
  endfunction

  // Predict, queue expectations, then hand the item over the input stream
  task automatic send_item(host_item_t it, bit typed, pager_result_t want, output bit used);
    int gap;
    used = pager_predict(it);
    if (typed) expected_q.push_back(want);
    else foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, it.bstat, it.bword, it.wdata, it.addr};
    s_tuser  <= it.kind;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_host(logic [1:0] kind, logic [19:0] addr, logic [35:0] wdata,
                           logic [15:0] bword, logic [1:0] bstat);
    host_item_t    it;
    pager_result_t none;
    bit            used;
    it = '{kind, addr, wdata, bword, bstat};
    none = '{'0, '0, '0, '0, '0, 1'b0};
    send_item(it, 1'b0, none, used);
    if (used) items_random++;
  endtask

  function automatic void plan(logic [1:0] kind, logic [19:0] addr, logic [35:0] wdata,
                               logic [15:0] bword, logic [1:0] bstat, bit typed = 1'b0,
                               logic [1:0] rkind = uwp_pkg::RK_DONE,
                               logic [35:0] rdata = '0);
    stim_row_t row;
    row.it    = '{kind, addr, wdata, bword, bstat};
    row.typed = typed;
    row.want  = '{rkind, rdata, '0, '0, '0, 1'b1};
    plan_q.push_back(row);
  endfunction

  // Address inside a page window, offset mostly within the entry limit
  function automatic logic [19:0] window_addr(logic [7:0] pg);
    logic [9:0] lim;
    logic [9:0] ofs;
    logic [1:0] hi;
    int         r;
    lim = pager_table[pg][uwp_pkg::E_LIMIT_LSB +: uwp_pkg::OFS_W];
    r   = $urandom_range(0, 99);
    if (r < 80) ofs = 10'($urandom_range(0, lim));
    else if (r < 90) ofs = lim;
    else ofs = 10'($urandom_range(0, 1023));
    hi = (pg == 8'hFF) ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
    return {hi, pg, ofs};
  endfunction

  function automatic logic [7:0] pick_page();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(240, 255));
    return 8'($urandom_range(0, 15));
  endfunction

  function automatic logic [1:0] pick_bstat();
    if ($urandom_range(0, 9) < 7) return uwp_pkg::BSTAT_ACK;
    return ($urandom_range(0, 1) == 0) ? BSTAT_ERR : BSTAT_TMO;
  endfunction

  function automatic logic [35:0] rand_entry();
    logic [35:0] ent;
    ent = rand_word36();
    ent[uwp_pkg::E_VALID_BIT] = ($urandom_range(0, 99) < 85);
    case ($urandom_range(0, 7))
      0: ent[uwp_pkg::E_LIMIT_LSB +: uwp_pkg::OFS_W] = 10'h000;
      1: ent[uwp_pkg::E_LIMIT_LSB +: uwp_pkg::OFS_W] = 10'h3FF;
      default: ;
    endcase
    return ent;
  endfunction

  task automatic program_page(logic [7:0] pg);
    send_host(uwp_pkg::KIND_WRITE, uwp_pkg::CTRL_BASE + 20'(pg), rand_entry(),
              16'($urandom()), pick_bstat());
  endtask

  task automatic bus_return();
    send_host(uwp_pkg::KIND_DATA, 20'($urandom()), rand_word36(), 16'($urandom()),
              pick_bstat());
  endtask

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold = 0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      ready_hold = idle_len();
    end else begin
      m_tready <= 1'b1;
      ready_hold = $urandom_range(0, 8);
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t: result %0d %s: got %h, want %h", $time, n_checked, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = '{m_tuser, m_tdata[35:0], m_tdata[38:36], m_tdata[57:39], m_tdata[73:58],
                  m_tlast};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(m_tdata), 64'(m_tuser));
      end else begin
        want_res = expected_q.pop_front();
        if (got_res.rkind !== want_res.rkind)
          report_mismatch("result_kind", 64'(got_res.rkind), 64'(want_res.rkind));
        if (got_res.rdata !== want_res.rdata)
          report_mismatch("read_data", 64'(got_res.rdata), 64'(want_res.rdata));
        if (got_res.bus !== want_res.bus)
          report_mismatch("bus_number", 64'(got_res.bus), 64'(want_res.bus));
        if (got_res.baddr !== want_res.baddr)
          report_mismatch("bus_address", 64'(got_res.baddr), 64'(want_res.baddr));
        if (got_res.bdata !== want_res.bdata)
          report_mismatch("bus_data", 64'(got_res.bdata), 64'(want_res.bdata));
        if (got_res.last !== want_res.last)
          report_mismatch("last", 64'(got_res.last), 64'(want_res.last));
        case (want_res.rkind)
          uwp_pkg::RK_DONE:   n_done++;
          uwp_pkg::RK_FAULT:  n_fault++;
          uwp_pkg::RK_BUS_RD: n_bus_rd++;
          default:            n_bus_wr++;
        endcase
      end
      n_checked++;
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("unibus_window_pager_core_test: done, errors");
    $finish;
  end

  // Stimulus
  initial begin
    bit          used;
    logic [7:0]  pg;
    int          r;
    pager_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: table empty after reset, control page bounds, windows at the extremes
    plan(uwp_pkg::KIND_READ, uwp_pkg::CTRL_BASE, '0, '0, uwp_pkg::BSTAT_ACK,
         1, uwp_pkg::RK_DONE, '0);
    plan(uwp_pkg::KIND_READ, uwp_pkg::CTRL_BASE + 20'o377, '0, '0, uwp_pkg::BSTAT_ACK,
         1, uwp_pkg::RK_DONE, '0);
    plan(uwp_pkg::KIND_READ, uwp_pkg::CTRL_BASE + 20'o400, '0, '0, uwp_pkg::BSTAT_ACK,
         1, uwp_pkg::RK_FAULT);
    plan(uwp_pkg::KIND_WRITE, 20'hFFFFF, 36'hFFFFFFFFF, 16'hFFFF, BSTAT_TMO,
         1, uwp_pkg::RK_FAULT);
    plan(uwp_pkg::KIND_READ, 20'h00000, '0, '0, uwp_pkg::BSTAT_ACK, 1, uwp_pkg::RK_FAULT);
    plan(uwp_pkg::KIND_WRITE, uwp_pkg::CTRL_BASE, ENT_TOP, '0, uwp_pkg::BSTAT_ACK,
         1, uwp_pkg::RK_DONE, '0);
    plan(uwp_pkg::KIND_WRITE, uwp_pkg::CTRL_BASE + 20'o377, ENT_ZERO, '0,
         uwp_pkg::BSTAT_ACK, 1, uwp_pkg::RK_DONE, '0);
    plan(uwp_pkg::KIND_WRITE, uwp_pkg::CTRL_BASE + 20'o1, ENT_WP, '0, uwp_pkg::BSTAT_ACK,
         1, uwp_pkg::RK_DONE, '0);
    // read at the top of the biggest window; base plus offset carries into bus address bit 18
    plan(uwp_pkg::KIND_READ,  20'o1777, '0, '0,       uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_DATA,  '0,       '0, 16'hFFFF, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_DATA,  '0,       '0, 16'hFFFF, uwp_pkg::BSTAT_ACK);
    // zero-limit window; error and timeout halves read as zero
    plan(uwp_pkg::KIND_READ,  20'h3FC00, '0, '0,       uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_DATA,  '0,        '0, 16'h1234, BSTAT_ERR);
    plan(uwp_pkg::KIND_DATA,  '0,        '0, 16'hFFFF, BSTAT_TMO);
    // stray return with nothing outstanding
    plan(uwp_pkg::KIND_DATA,  '0,        '0, 16'hABCD, uwp_pkg::BSTAT_ACK);
    // writes through a write-protected entry: both, second only, first only, none
    plan(uwp_pkg::KIND_WRITE, 20'hC0405, 36'hFFFFFFFF3, '0, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_WRITE, 20'h00405, 36'hABCD12348, '0, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_WRITE, 20'h00405, 36'h5555AAAA4, '0, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_WRITE, 20'h00405, 36'hFFFFFFFFC, '0, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_WRITE, 20'h00410, 36'h000000000, '0, uwp_pkg::BSTAT_ACK,
         1, uwp_pkg::RK_FAULT);
    // control page read abandons a half-collected read
    plan(uwp_pkg::KIND_READ,  20'h00403, '0, '0,       uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_DATA,  '0,        '0, 16'h8001, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_READ,  uwp_pkg::CTRL_BASE + 20'o1, '0, '0, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_DATA,  '0,        '0, 16'h1111, uwp_pkg::BSTAT_ACK);
    // unknown kind and a write leave a pending read alone; odd status reads as zero
    plan(uwp_pkg::KIND_READ,  20'h00400, '0, '0, uwp_pkg::BSTAT_ACK);
    plan(KIND_UNUSED, 20'h00400, 36'hFFFFFFFFF, 16'hFFFF, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_WRITE, 20'h00401, 36'h00000000C, '0, uwp_pkg::BSTAT_ACK);
    plan(uwp_pkg::KIND_DATA,  '0,        '0, 16'h7777, BSTAT_BAD);
    plan(uwp_pkg::KIND_DATA,  20'hFFFFF, 36'hFFFFFFFFF, 16'h0001, uwp_pkg::BSTAT_ACK);

    foreach (plan_q[i]) begin
      send_item(plan_q[i].it, plan_q[i].typed, plan_q[i].want, used);
      items_directed++;
    end

    // Random: map the page pool, then mixed traffic over it
    for (int p = 0; p < 16; p++) program_page(8'(p));
    for (int p = 240; p < 256; p++) program_page(8'(p));

    while (items_random < 410) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      pg = pick_page();
      r  = $urandom_range(0, 99);
      if (r < 15) begin
        program_page(pg);
      end else if (r < 25) begin
        send_host(uwp_pkg::KIND_READ,
                  uwp_pkg::CTRL_BASE + 20'(($urandom_range(0, 6) == 0)
                                           ? $urandom_range(256, 1023)
                                           : $urandom_range(0, 255)),
                  rand_word36(), 16'($urandom()), pick_bstat());
      end else if (r < 60) begin
        // read, usually followed by its two halves
        send_host(uwp_pkg::KIND_READ, window_addr(pg), rand_word36(), 16'($urandom()),
                  pick_bstat());
        r = $urandom_range(0, 99);
        if (r < 90) bus_return();
        if (r >= 70 && r < 80)
          send_host(uwp_pkg::KIND_WRITE, window_addr(pick_page()), rand_word36(),
                    16'($urandom()), pick_bstat());
        if (r < 80) bus_return();
      end else if (r < 90) begin
        send_host(uwp_pkg::KIND_WRITE, window_addr(pg), rand_word36(), 16'($urandom()),
                  pick_bstat());
      end else begin
        // noise: stray returns, random addresses, unknown kind
        r = $urandom_range(0, 9);
        if (r < 4) bus_return();
        else if (r < 9)
          send_host(2'($urandom_range(0, 1)), 20'($urandom()), rand_word36(),
                    16'($urandom()), pick_bstat());
        else
          send_host(KIND_UNUSED, 20'($urandom()), rand_word36(), 16'($urandom()), 2'($urandom()));
      end
    end

    // Drain
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d directed and %0d random host transactions; %0d results checked",
             items_directed, items_random, n_checked);
    $display("Results: %0d done, %0d faults, %0d bus reads, %0d bus writes; %0d mismatches",
             n_done, n_fault, n_bus_rd, n_bus_wr, errors);
    if (errors == 0)
      $display("unibus_window_pager_core_test: done, clean");
    else
      $display("unibus_window_pager_core_test: done, errors");
    $finish;
  end

endmodule

// ===== unibus_window_pager_core.f =====
hw/rtl/uwp_pkg.sv
hw/rtl/uwp_table.sv
hw/rtl/uwp_ctrl.sv
hw/rtl/unibus_window_pager_core.sv
verif/unibus_window_pager_core_test.sv
